FILE: rtl/nearest_center_word_histogram_assert.svh
// Assertion macros shared by the histogram block.
// Needs nothing else; define ASSERT_OFF to compile the checks away.
`ifndef NEAREST_CENTER_WORD_HISTOGRAM_ASSERT_SVH
`define NEAREST_CENTER_WORD_HISTOGRAM_ASSERT_SVH
`ifndef ASSERT_OFF
// The condition must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed");
// When the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_NEVER(label, clk, rst_n, cond)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/ncwh_pkg.sv
// Shared types and constants of the nearest-center word histogram.
// Used by the controller, the datapath and the top level; depends on nothing.
package ncwh_pkg;

    localparam int DEF_MAX_CENTERS = 64;
    localparam int DEF_MAX_DIMS    = 256;

    localparam int SAMPLE_W = 16;
    localparam int SQ_W     = 32;
    localparam int SUM_W    = 40;
    localparam int COUNT_W  = 16;
    localparam int CI_W     = 6;
    localparam int DI_W     = 8;
    localparam int CC_W     = 7;
    localparam int DU_W     = 9;
    localparam int CFG_W    = 9;

    localparam logic [CC_W-1:0] CENTER_COUNT_RESET = 7'd64;
    localparam logic [DU_W-1:0] DIMS_RESET         = 9'd250;
    localparam logic [COUNT_W-1:0] BIN_MAX         = 16'hFFFF;

    // Configuration register indexes.
    localparam logic [0:0] REG_CENTER_COUNT = 1'b0;
    localparam logic [0:0] REG_DIMS_IN_USE  = 1'b1;

    typedef enum logic [1:0] {
        KIND_CB_WRITE = 2'd0,
        KIND_DESC     = 2'd1,
        KIND_END      = 2'd2
    } kind_t;

    typedef struct packed {
        logic cb_we;
        logic latch_item;
        logic acc_issue;
        logic dist_clear;
        logic hist_rd;
        logic hist_sel_best;
        logic hist_inc;
        logic out_load;
        logic out_last;
        logic hist_clear;
    } ncwh_cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic out_take;
    } ncwh_status_t;

endpackage

FILE: rtl/nearest_center_word_histogram.sv
// Each descriptor element runs the n active centers, one center per cycle, through the
// shared subtract-square-accumulate pipeline; the last element of a descriptor then adds
// the bin update. An end of instance reads out each bin in turn, then loads it into the
// output register and holds it until taken. Reset is asynchronous and active low; it
// clears control state and the valid bits of the distance and histogram stores at once,
// so there is no clearing pass. The codebook is not cleared and holds garbage until written.
`include "nearest_center_word_histogram_assert.svh"
module nearest_center_word_histogram
    import ncwh_pkg::*;
#(
    parameter int MAX_CENTERS = DEF_MAX_CENTERS,
    parameter int MAX_DIMS    = DEF_MAX_DIMS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [0:0]       cfg_addr,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             s_tvalid,
    output logic             s_tready,
    // Fields from bit 0: center_index[5:0], dim_index[13:6], sample_value[29:14], zero pad.
    input  logic [31:0]      s_tdata,
    // Fields from bit 0: kind[1:0].
    input  logic [1:0]       s_tuser,
    output logic             m_tvalid,
    input  logic             m_tready,
    // Fields from bit 0: bin_index[5:0], bin_count[21:6], zero pad.
    output logic [23:0]      m_tdata,
    output logic             m_tlast
);

    localparam int CW = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;

    ncwh_cmd_t          cmd;
    ncwh_status_t       status;
    logic [CW-1:0]      k;
    logic [CI_W-1:0]    bin_index;
    logic [COUNT_W-1:0] bin_count;

    ncwh_ctrl #(
        .MAX_CENTERS (MAX_CENTERS),
        .MAX_DIMS    (MAX_DIMS),
        .CW          (CW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_kind  (s_tuser),
        .in_ci    (s_tdata[5:0]),
        .in_di    (s_tdata[13:6]),
        .status   (status),
        .cmd      (cmd),
        .k        (k)
    );

    ncwh_datapath #(
        .MAX_CENTERS (MAX_CENTERS),
        .MAX_DIMS    (MAX_DIMS),
        .CW          (CW)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .k         (k),
        .in_ci     (s_tdata[5:0]),
        .in_di     (s_tdata[13:6]),
        .in_val    (s_tdata[29:14]),
        .status    (status),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .bin_index (bin_index),
        .bin_count (bin_count),
        .bin_last  (m_tlast)
    );

    assign m_tdata = {2'b00, bin_count, bin_index};

    // Requests are taken only while no histogram readout is under way.
    `ASSERT_NEVER(a_no_accept_during_readout, clk, rst_n, s_tready && m_tvalid)
    // The final bin leaves the block ready for the next request.
    `ASSERT_NEXT(a_idle_after_last_bin, clk, rst_n, m_tvalid && m_tready && m_tlast, s_tready)
    // An end-of-instance request always starts a readout.
    `ASSERT_NEXT(a_end_starts_readout, clk, rst_n,
        s_tvalid && s_tready && (s_tuser == KIND_END), !s_tready)

endmodule

FILE: rtl/ncwh_datapath.sv
// Datapath: codebook memory, shared subtract-square-accumulate pipeline,
// distance and histogram memories, nearest-center search and output register.
// Depends on ncwh_pkg; driven by ncwh_ctrl.
module ncwh_datapath
    import ncwh_pkg::*;
#(
    parameter int MAX_CENTERS = DEF_MAX_CENTERS,
    parameter int MAX_DIMS    = DEF_MAX_DIMS,
    parameter int CW          = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ncwh_cmd_t           cmd,
    input  logic [CW-1:0]       k,
    input  logic [CI_W-1:0]     in_ci,
    input  logic [DI_W-1:0]     in_di,
    input  logic [SAMPLE_W-1:0] in_val,
    output ncwh_status_t        status,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [CI_W-1:0]     bin_index,
    output logic [COUNT_W-1:0]  bin_count,
    output logic                bin_last
);

    localparam int DW       = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int AW       = CW + DW;
    localparam int CB_DEPTH = 2 ** AW;

    logic [SAMPLE_W-1:0] cb_mem [CB_DEPTH];
    logic [SUM_W-1:0]    dist_mem [MAX_CENTERS];
    logic [COUNT_W-1:0]  hist_mem [MAX_CENTERS];

    logic [DI_W-1:0]     di_reg;
    logic [SAMPLE_W-1:0] val_reg;

    logic [15:0]         in_di_w;
    logic [15:0]         di_reg_w;
    logic [AW-1:0]       cb_wr_addr;
    logic [AW-1:0]       cb_rd_addr;
    logic [SAMPLE_W-1:0] cb_rd_reg;

    logic                p1_valid_reg, p2_valid_reg, p3_valid_reg;
    logic [CW-1:0]       p1_k_reg, p2_k_reg, p3_k_reg;
    logic [SAMPLE_W-1:0] p2_diff_reg;
    logic [SAMPLE_W-1:0] diff;
    logic [SQ_W-1:0]     p3_sq_reg;
    logic [SUM_W-1:0]    dist_rd_reg;
    logic                dist_rv_reg;
    logic [MAX_CENTERS-1:0] dist_valid_reg;

    logic [SUM_W:0]      sum_wide;
    logic [SUM_W-1:0]    sum_sat;
    logic [SUM_W-1:0]    best_reg;
    logic [CW-1:0]       best_idx_reg;

    logic [MAX_CENTERS-1:0] hist_valid_reg;
    logic [CW-1:0]       hist_addr;
    logic [COUNT_W-1:0]  hist_rd_reg;
    logic                hist_rv_reg;
    logic [COUNT_W-1:0]  hist_cur;
    logic [COUNT_W-1:0]  hist_inc_val;

    logic                out_valid_reg;
    logic [CW-1:0]       out_idx_reg;
    logic [COUNT_W-1:0]  out_cnt_reg;
    logic                out_last_reg;

    assign in_di_w    = 16'(in_di);
    assign di_reg_w   = 16'(di_reg);
    assign cb_wr_addr = {in_ci[CW-1:0], in_di_w[DW-1:0]};
    assign cb_rd_addr = {k, di_reg_w[DW-1:0]};

    // Codebook store and held descriptor element.
    always_ff @(posedge clk)
    begin
        if (cmd.cb_we)
        begin
            cb_mem[cb_wr_addr] <= in_val;
        end
        cb_rd_reg <= cb_mem[cb_rd_addr];
        if (cmd.latch_item)
        begin
            di_reg  <= in_di;
            val_reg <= in_val;
        end
    end

    // Pipeline control: one center enters per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= cmd.acc_issue;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
        end
    end

    assign diff = (val_reg > cb_rd_reg) ? (val_reg - cb_rd_reg) : (cb_rd_reg - val_reg);

    always_ff @(posedge clk)
    begin
        p1_k_reg    <= k;
        p2_k_reg    <= p1_k_reg;
        p3_k_reg    <= p2_k_reg;
        p2_diff_reg <= diff;
        p3_sq_reg   <= SQ_W'(p2_diff_reg) * SQ_W'(p2_diff_reg);
        dist_rd_reg <= dist_mem[p2_k_reg];
        dist_rv_reg <= dist_valid_reg[p2_k_reg];
    end

    assign sum_wide = (dist_rv_reg ? {1'b0, dist_rd_reg} : '0) + (SUM_W + 1)'(p3_sq_reg);
    assign sum_sat  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

    always_ff @(posedge clk)
    begin
        if (p3_valid_reg)
        begin
            dist_mem[p3_k_reg] <= sum_sat;
            // Centers come in ascending order, so a strict compare keeps the lowest index.
            if ((p3_k_reg == '0) || (sum_sat < best_reg))
            begin
                best_reg     <= sum_sat;
                best_idx_reg <= p3_k_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_valid_reg <= '0;
        end
        else if (cmd.dist_clear)
        begin
            dist_valid_reg <= '0;
        end
        else if (p3_valid_reg)
        begin
            dist_valid_reg[p3_k_reg] <= 1'b1;
        end
    end

    // Histogram store: one read port shared by the bin update and the readout.
    assign hist_addr    = cmd.hist_sel_best ? best_idx_reg : k;
    assign hist_cur     = hist_rv_reg ? hist_rd_reg : '0;
    assign hist_inc_val = (hist_cur == BIN_MAX) ? BIN_MAX : (hist_cur + COUNT_W'(1));

    always_ff @(posedge clk)
    begin
        if (cmd.hist_rd)
        begin
            hist_rd_reg <= hist_mem[hist_addr];
            hist_rv_reg <= hist_valid_reg[hist_addr];
        end
        if (cmd.hist_inc)
        begin
            hist_mem[best_idx_reg] <= hist_inc_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_valid_reg <= '0;
        end
        else if (cmd.hist_clear)
        begin
            hist_valid_reg <= '0;
        end
        else if (cmd.hist_inc)
        begin
            hist_valid_reg[best_idx_reg] <= 1'b1;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_idx_reg  <= k;
            out_cnt_reg  <= hist_cur;
            out_last_reg <= cmd.out_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign bin_index = CI_W'(out_idx_reg);
    assign bin_count = out_cnt_reg;
    assign bin_last  = out_last_reg;

    assign status.pipe_busy = p1_valid_reg | p2_valid_reg | p3_valid_reg;
    assign status.out_take  = out_valid_reg & out_ready;

endmodule

FILE: rtl/ncwh_ctrl.sv
// Controller: configuration registers, request decode and the sequencer
// that drives the datapath. Depends on ncwh_pkg.
module ncwh_ctrl
    import ncwh_pkg::*;
#(
    parameter int MAX_CENTERS = DEF_MAX_CENTERS,
    parameter int MAX_DIMS    = DEF_MAX_DIMS,
    parameter int CW          = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [0:0]       cfg_addr,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       in_kind,
    input  logic [CI_W-1:0]  in_ci,
    input  logic [DI_W-1:0]  in_di,
    input  ncwh_status_t     status,
    output ncwh_cmd_t        cmd,
    output logic [CW-1:0]    k
);

    localparam int DIM_CAP = (MAX_DIMS < 256) ? MAX_DIMS : 256;

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_ACC       = 8'b0000_0010,
        ST_DRAIN     = 8'b0000_0100,
        ST_INC_RD    = 8'b0000_1000,
        ST_INC_WR    = 8'b0001_0000,
        ST_EMIT_RD   = 8'b0010_0000,
        ST_EMIT_LD   = 8'b0100_0000,
        ST_EMIT_HOLD = 8'b1000_0000
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   k_reg, k_next;
    logic            desc_last_reg, desc_last_next;
    logic [CC_W-1:0] center_count_reg;
    logic [DU_W-1:0] dims_in_use_reg;

    logic [CC_W-1:0] eff_centers;
    logic [DU_W-1:0] eff_dims;
    logic [CW-1:0]   last_k;
    logic [DI_W-1:0] last_d;
    logic            cb_in_range;
    logic            di_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_count_reg <= CENTER_COUNT_RESET;
            dims_in_use_reg  <= DIMS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_CENTER_COUNT: center_count_reg <= cfg_data[CC_W-1:0];
                REG_DIMS_IN_USE:  dims_in_use_reg  <= cfg_data[DU_W-1:0];
                default: ;
            endcase
        end
    end

    // Out-of-range settings saturate to the supported span.
    always_comb
    begin
        if (center_count_reg == '0)
            eff_centers = CC_W'(1);
        else if (center_count_reg > CC_W'(MAX_CENTERS))
            eff_centers = CC_W'(MAX_CENTERS);
        else
            eff_centers = center_count_reg;
        if (dims_in_use_reg == '0)
            eff_dims = DU_W'(1);
        else if (dims_in_use_reg > DU_W'(DIM_CAP))
            eff_dims = DU_W'(DIM_CAP);
        else
            eff_dims = dims_in_use_reg;
    end

    assign last_k      = CW'(eff_centers - CC_W'(1));
    assign last_d      = DI_W'(eff_dims - DU_W'(1));
    assign cb_in_range = (CC_W'(in_ci) < CC_W'(MAX_CENTERS)) && (11'(in_di) < 11'(MAX_DIMS));
    assign di_ok       = (DU_W'(in_di) < eff_dims);

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        desc_last_next = desc_last_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (in_kind)
                        KIND_CB_WRITE:
                        begin
                            cmd.cb_we = cb_in_range;
                        end
                        KIND_DESC:
                        begin
                            if (di_ok)
                            begin
                                cmd.latch_item = 1'b1;
                                desc_last_next = (in_di == last_d);
                                k_next         = '0;
                                state_next     = ST_ACC;
                            end
                        end
                        KIND_END:
                        begin
                            cmd.dist_clear = 1'b1;
                            k_next         = '0;
                            state_next     = ST_EMIT_RD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ACC:
            begin
                cmd.acc_issue = 1'b1;
                if (k_reg == last_k)
                    state_next = ST_DRAIN;
                else
                    k_next = k_reg + CW'(1);
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                    state_next = desc_last_reg ? ST_INC_RD : ST_IDLE;
            end
            ST_INC_RD:
            begin
                cmd.hist_rd       = 1'b1;
                cmd.hist_sel_best = 1'b1;
                cmd.dist_clear    = 1'b1;
                state_next        = ST_INC_WR;
            end
            ST_INC_WR:
            begin
                cmd.hist_inc = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_EMIT_RD:
            begin
                cmd.hist_rd = 1'b1;
                state_next  = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                cmd.out_load = 1'b1;
                cmd.out_last = (k_reg == last_k);
                state_next   = ST_EMIT_HOLD;
            end
            ST_EMIT_HOLD:
            begin
                if (status.out_take)
                begin
                    if (k_reg == last_k)
                    begin
                        cmd.hist_clear = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + CW'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            desc_last_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            desc_last_reg <= desc_last_next;
        end
    end

    assign k = k_reg;

endmodule

FILE: dv/tb_nearest_center_word_histogram.sv
// Self-checking testbench for the nearest-center word histogram block.
// Drives codebook, descriptor and end-of-instance requests and predicts every histogram bin.
// Depends on ncwh_pkg and the nearest_center_word_histogram RTL.
module tb_nearest_center_word_histogram;
    timeunit 1ns;
    timeprecision 1ps;
    import ncwh_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int STALL_CYCLES = 1500;
    localparam int SETTLE_CYCLES = 200;
    localparam int RANDOM_ITEMS = 270;

    typedef struct packed {
        logic [CI_W-1:0]    index;
        logic [COUNT_W-1:0] count;
        logic               last;
    } bin_report_t;

    // Shadow copy of the codebook, the distance sums and the histogram.
    class bow_histogram;
        bit [SAMPLE_W-1:0] codebook_copy [DEF_MAX_CENTERS][DEF_MAX_DIMS];
        bit                written [DEF_MAX_CENTERS][DEF_MAX_DIMS];
        bit [SUM_W-1:0]    sums [DEF_MAX_CENTERS];
        bit [COUNT_W-1:0]  counts [DEF_MAX_CENTERS];
        int unsigned       centers_on;
        int unsigned       dims_on;
        bin_report_t       bins_due [$];
        int                mismatches;

        function new();
            centers_on = CENTER_COUNT_RESET;
            dims_on = DIMS_RESET;
            mismatches = 0;
        endfunction

        function void write_reg(logic [0:0] idx, logic [CFG_W-1:0] value);
            int unsigned v;
            if (idx == REG_CENTER_COUNT)
            begin
                v = value[CC_W-1:0];
                centers_on = (v < 1) ? 1 : ((v > DEF_MAX_CENTERS) ? DEF_MAX_CENTERS : v);
            end
            else
            begin
                v = value[DU_W-1:0];
                dims_on = (v < 1) ? 1 : ((v > 256) ? 256 : v);
            end
        endfunction

        function void take_request(logic [1:0] kind, logic [CI_W-1:0] ci,
                                   logic [DI_W-1:0] di, logic [SAMPLE_W-1:0] val);
            bit [SAMPLE_W-1:0] c;
            bit [SAMPLE_W-1:0] diff;
            bit [SQ_W-1:0]     sq;
            bit [SUM_W:0]      s;
            int unsigned       best;
            bin_report_t       r;
            case (kind)
                KIND_CB_WRITE:
                begin
                    codebook_copy[ci][di] = val;
                    written[ci][di] = 1'b1;
                end
                KIND_DESC:
                begin
                    if (di < dims_on)
                    begin
                        for (int k = 0; k < centers_on; k++)
                        begin
                            c = codebook_copy[k][di];
                            diff = (val > c) ? val - c : c - val;
                            sq = SQ_W'(diff) * SQ_W'(diff);
                            s = {1'b0, sums[k]} + sq;
                            sums[k] = s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
                        end
                        if (di == dims_on - 1)
                        begin
                            // Strict less-than keeps the lowest index on a tie.
                            best = 0;
                            for (int k = 1; k < centers_on; k++)
                                if (sums[k] < sums[best])
                                    best = k;
                            if (counts[best] != BIN_MAX)
                                counts[best]++;
                            foreach (sums[k])
                                sums[k] = '0;
                        end
                    end
                end
                KIND_END:
                begin
                    for (int k = 0; k < centers_on; k++)
                    begin
                        r.index = CI_W'(k);
                        r.count = counts[k];
                        r.last = (k == centers_on - 1);
                        bins_due = {bins_due, r};
                    end
                    foreach (sums[k])
                    begin
                        sums[k] = '0;
                        counts[k] = '0;
                    end
                end
                default:
                    ;
            endcase
        endfunction

        function void check_bin(logic [CI_W-1:0] idx, logic [COUNT_W-1:0] cnt, logic last);
            bin_report_t want;
            if (bins_due.size() == 0)
            begin
                $error("bin %0d arrived with no histogram pending", idx);
                mismatches++;
            end
            else
            begin
                want = bins_due.pop_front();
                if (idx !== want.index)
                begin
                    $error("bin_index expected %0d actual %0d", want.index, idx);
                    mismatches++;
                end
                if (cnt !== want.count)
                begin
                    $error("bin_count expected %0d actual %0d", want.count, cnt);
                    mismatches++;
                end
                if (last !== want.last)
                begin
                    $error("last_bin expected %0d actual %0d", want.last, last);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [0:0]       cfg_addr = REG_CENTER_COUNT;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [31:0]      s_tdata = '0;
    logic [1:0]       s_tuser = KIND_CB_WRITE;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [23:0]      m_tdata;
    logic             m_tlast;

    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    int          stall_ask = 0;
    int          stall_taken = 0;
    int          stall_left = 0;
    int unsigned useful_sent = 0;

    bow_histogram hist = new();

    always #5 clk = ~clk;

    nearest_center_word_histogram DUT (.*);

    // Result side: check accepted bins, then pick the next ready value.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            hist.check_bin(m_tdata[5:0], m_tdata[21:6], m_tlast);
        if (stall_taken != stall_ask)
        begin
            stall_taken = stall_ask;
            stall_left = STALL_CYCLES;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (rx_idle_on && $urandom_range(99) < 28)
            m_tready <= 1'b0;
        else
            m_tready <= 1'b1;
    end

    task automatic send_request(logic [1:0] kind, logic [CI_W-1:0] ci,
                                logic [DI_W-1:0] di, logic [SAMPLE_W-1:0] val);
        if (tx_idle_on)
            while ($urandom_range(99) < 28)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {2'b00, val, di, ci};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (kind != KIND_UNUSED && !(kind == KIND_DESC && di >= hist.dims_on))
            useful_sent++;
        hist.take_request(kind, ci, di, val);
    endtask

    task automatic set_reg(logic [0:0] idx, logic [CFG_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        hist.write_reg(idx, value);
        @(posedge clk);
    endtask

    // Wait for every pending bin, then give a trailing descriptor time to finish.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (hist.bins_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic fill_codebook(int unsigned n, int unsigned d);
        for (int k = 0; k < n; k++)
            for (int j = 0; j < d; j++)
                if (!hist.written[k][j])
                    send_request(KIND_CB_WRITE, CI_W'(k), DI_W'(j),
                                 SAMPLE_W'($urandom_range(65535)));
    endtask

    // Values near some center so the winner moves around, the extremes and uniform random values.
    function automatic logic [SAMPLE_W-1:0] pick_value(int unsigned n, logic [DI_W-1:0] di);
        int          r;
        int          base;
        int unsigned k;
        r = $urandom_range(9);
        if (r < 4)
        begin
            k = $urandom_range(n - 1);
            base = int'(hist.codebook_copy[k][di]) + int'($urandom_range(64)) - 32;
            if (base < 0)
                base = 0;
            if (base > 65535)
                base = 65535;
            return SAMPLE_W'(base);
        end
        else if (r == 4)
            return '0;
        else if (r == 5)
            return '1;
        return SAMPLE_W'($urandom_range(65535));
    endfunction

    task automatic send_noise(int unsigned d);
        int r;
        r = $urandom_range(9);
        if (r < 3)
            send_request(KIND_UNUSED, CI_W'($urandom_range(63)), DI_W'($urandom_range(255)),
                         SAMPLE_W'($urandom_range(65535)));
        else if (r < 6 && d < 256)
            send_request(KIND_DESC, CI_W'($urandom_range(63)), DI_W'($urandom_range(255, d)),
                         SAMPLE_W'($urandom_range(65535)));
        else if (r < 9)
            send_request(KIND_CB_WRITE, CI_W'($urandom_range(63)), DI_W'($urandom_range(255)),
                         SAMPLE_W'($urandom_range(65535)));
        else
            send_request(KIND_END, CI_W'($urandom_range(63)), DI_W'($urandom_range(255)),
                         SAMPLE_W'($urandom_range(65535)));
    endtask

    // One descriptor in shuffled order; the element at dims-1 closes it.
    task automatic send_descriptor(int unsigned d, int unsigned n);
        logic [DI_W-1:0] order [$];
        logic [DI_W-1:0] tmp;
        int unsigned     t;
        for (int i = 0; i < d - 1; i++)
            order = {order, DI_W'(i)};
        for (int i = int'(order.size()) - 1; i > 0; i--)
        begin
            t = $urandom_range(i);
            tmp = order[i];
            order[i] = order[t];
            order[t] = tmp;
        end
        order = {order, DI_W'(d - 1)};
        foreach (order[i])
        begin
            if ($urandom_range(99) < 8)
                send_noise(d);
            if (i < order.size() - 1 && $urandom_range(99) < 4)
                send_request(KIND_DESC, CI_W'($urandom_range(63)), order[i],
                             pick_value(n, order[i]));
            send_request(KIND_DESC, CI_W'($urandom_range(63)), order[i],
                         pick_value(n, order[i]));
        end
    endtask

    initial
    begin
        int unsigned    start;
        int unsigned    n;
        int unsigned    d;
        int unsigned    sel;
        int unsigned    phase;
        int unsigned    reps;
        logic [CC_W-1:0] cc_raw;
        logic [DU_W-1:0] du_raw;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: an element beyond 250 dims is dropped and all 64 bins come out.
        send_request(KIND_DESC, 6'd0, 8'd255, 16'h1234);
        send_request(KIND_UNUSED, 6'd63, 8'd255, 16'hFFFF);
        send_request(KIND_END, 6'd0, 8'd0, 16'h0000);
        settle();

        set_reg(REG_CENTER_COUNT, 9'd4);
        set_reg(REG_DIMS_IN_USE, 9'd3);
        send_request(KIND_CB_WRITE, 6'd63, 8'd255, 16'hA5A5);
        for (int j = 0; j < 3; j++)
        begin
            send_request(KIND_CB_WRITE, 6'd0, DI_W'(j), 16'h0000);
            send_request(KIND_CB_WRITE, 6'd1, DI_W'(j), 16'hFFFF);
            send_request(KIND_CB_WRITE, 6'd2, DI_W'(j), 16'h8000);
            send_request(KIND_CB_WRITE, 6'd3, DI_W'(j), 16'h0000);
        end
        // Centers zero and three tie; the lower index must win.
        for (int j = 0; j < 3; j++)
            send_request(KIND_DESC, 6'd0, DI_W'(j), 16'h0000);
        // Out of order, with an out-of-range element and an unused kind in between.
        send_request(KIND_DESC, 6'd0, 8'd1, 16'hFFFF);
        send_request(KIND_DESC, 6'd0, 8'd200, 16'h0000);
        send_request(KIND_UNUSED, 6'd5, 8'd1, 16'h0000);
        send_request(KIND_DESC, 6'd0, 8'd0, 16'hFFFF);
        send_request(KIND_DESC, 6'd0, 8'd2, 16'hFFFF);
        send_request(KIND_DESC, 6'd0, 8'd0, 16'h8000);
        send_request(KIND_DESC, 6'd0, 8'd1, 16'h7F00);
        send_request(KIND_DESC, 6'd0, 8'd2, 16'h8100);
        send_request(KIND_END, 6'd0, 8'd0, 16'h0000);
        // An unfinished descriptor is dropped by the end of instance.
        send_request(KIND_DESC, 6'd0, 8'd0, 16'hFFFF);
        send_request(KIND_DESC, 6'd0, 8'd1, 16'hFFFF);
        send_request(KIND_END, 6'd0, 8'd0, 16'h0000);
        // The last element closes the descriptor even with a middle one missing.
        send_request(KIND_DESC, 6'd0, 8'd0, 16'hFFFF);
        send_request(KIND_DESC, 6'd0, 8'd2, 16'hFFFF);
        send_request(KIND_END, 6'd0, 8'd0, 16'h0000);
        settle();

        // Both registers saturate: 127 centers become 64, zero dims become one.
        set_reg(REG_CENTER_COUNT, 9'd127);
        set_reg(REG_DIMS_IN_USE, 9'd0);
        fill_codebook(64, 1);
        send_request(KIND_DESC, 6'd0, 8'd0, 16'h0000);
        send_request(KIND_DESC, 6'd0, 8'd0, 16'hFFFF);
        send_request(KIND_DESC, 6'd0, 8'd0, SAMPLE_W'($urandom_range(65535)));
        send_request(KIND_END, 6'd0, 8'd0, 16'h0000);
        settle();

        // Hold the result side off so the output path backs up into the input.
        set_reg(REG_CENTER_COUNT, 9'd64);
        set_reg(REG_DIMS_IN_USE, 9'd1);
        stall_ask <= stall_ask + 1;
        repeat (8)
        begin
            send_request(KIND_DESC, 6'd0, 8'd0, pick_value(64, 8'd0));
            send_request(KIND_END, 6'd0, 8'd0, 16'h0000);
        end
        settle();

        // Zero centers act as one and 511 dims as 256, so element 255 closes a descriptor.
        set_reg(REG_CENTER_COUNT, 9'd0);
        set_reg(REG_DIMS_IN_USE, 9'd511);
        send_request(KIND_CB_WRITE, 6'd0, 8'd255, SAMPLE_W'($urandom_range(65535)));
        send_request(KIND_DESC, 6'd0, 8'd255, SAMPLE_W'($urandom_range(65535)));
        send_request(KIND_END, 6'd0, 8'd0, 16'h0000);
        settle();
        set_reg(REG_DIMS_IN_USE, 9'd256);
        send_request(KIND_DESC, 6'd0, 8'd255, SAMPLE_W'($urandom_range(65535)));
        send_request(KIND_DESC, 6'd0, 8'd255, SAMPLE_W'($urandom_range(65535)));
        send_request(KIND_END, 6'd0, 8'd0, 16'h0000);
        settle();

        start = useful_sent;
        phase = 0;
        while (useful_sent - start < RANDOM_ITEMS)
        begin
            settle();
            sel = $urandom_range(15);
            if (sel <= 10)
            begin
                n = $urandom_range(1, 8);
                d = $urandom_range(1, 8);
            end
            else if (sel <= 12)
            begin
                n = $urandom_range(33, 64);
                d = $urandom_range(1, 3);
            end
            else if (sel == 13)
            begin
                n = $urandom_range(1, 2);
                d = $urandom_range(32, 64);
            end
            else
            begin
                n = $urandom_range(9, 20);
                d = $urandom_range(9, 20);
            end
            cc_raw = CC_W'(n);
            if (n == 1 && $urandom_range(1))
                cc_raw = '0;
            if (n == 64 && $urandom_range(1))
                cc_raw = CC_W'($urandom_range(65, 127));
            du_raw = DU_W'(d);
            if (d == 1 && $urandom_range(1))
                du_raw = '0;
            set_reg(REG_CENTER_COUNT, {2'($urandom_range(3)), cc_raw});
            set_reg(REG_DIMS_IN_USE, du_raw);
            fill_codebook(n, d);
            tx_idle_on = (phase != 2);
            rx_idle_on <= (phase != 2);
            reps = (sel == 13) ? 1 : $urandom_range(1, 3);
            repeat (reps)
            begin
                repeat ((sel == 13) ? 1 : $urandom_range(1, 5))
                    send_descriptor(d, n);
                send_request(KIND_END, CI_W'($urandom_range(63)), DI_W'($urandom_range(255)),
                             SAMPLE_W'($urandom_range(65535)));
            end
            phase++;
        end

        settle();
        if (hist.mismatches == 0 && hist.bins_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #100ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/ncwh_pkg.sv
rtl/ncwh_datapath.sv
rtl/ncwh_ctrl.sv
rtl/nearest_center_word_histogram.sv
dv/tb_nearest_center_word_histogram.sv
